>>> hw/rtl/hpf_pkg.sv
// Shared types and constants of the heatmap peak finder.
package hpf_pkg;

   // Width of a configuration threshold register
   localparam int CFG_BITS = 16;

   // Reset values of the thresholds, 0.1 in Q1.14
   localparam logic [CFG_BITS-1:0] PEAK_THR_RESET  = 16'd1638;
   localparam logic [CFG_BITS-1:0] VALID_THR_RESET = 16'd1638;

   // Configuration register indexes
   typedef enum logic [0:0] {
      REG_PEAK_THR  = 1'b0,
      REG_VALID_THR = 1'b1
   } reg_index_type;

   // Threshold registers as seen by the datapath
   typedef struct packed {
      logic [CFG_BITS-1:0] peak_thr;
      logic [CFG_BITS-1:0] valid_thr;
   } cfg_type;

   // Position class of one sample, set by the front end
   typedef struct packed {
      logic restart;    // first sample of a new map
      logic first_col;  // sample lies in column 0
      logic end_row;    // sample is the last row of its column
      logic last_col;   // sample lies in the last column
   } flags_type;

   localparam int FLAGS_BITS = $bits(flags_type);

endpackage

>>> hw/rtl/hpf_csr.sv
// Configuration register file of the heatmap peak finder (APB-style port).
module hpf_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output hpf_pkg::cfg_type    cfg
);

   logic [hpf_pkg::CFG_BITS-1:0] peak_thr_ff, peak_thr_in;
   logic [hpf_pkg::CFG_BITS-1:0] valid_thr_ff, valid_thr_in;
   hpf_pkg::reg_index_type       reg_sel;
   logic                         wr_en;

   assign reg_sel    = hpf_pkg::reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Decode the write
   always_comb begin
      peak_thr_in  = peak_thr_ff;
      valid_thr_in = valid_thr_ff;
      if (wr_en) begin
         case (reg_sel)
            hpf_pkg::REG_PEAK_THR:  peak_thr_in  = csr_pwdata[hpf_pkg::CFG_BITS-1:0];
            hpf_pkg::REG_VALID_THR: valid_thr_in = csr_pwdata[hpf_pkg::CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_thr_ff  <= hpf_pkg::PEAK_THR_RESET;
         valid_thr_ff <= hpf_pkg::VALID_THR_RESET;
      end else begin
         peak_thr_ff  <= peak_thr_in;
         valid_thr_ff <= valid_thr_in;
      end
   end

   // Read back the selected register
   always_comb begin
      case (reg_sel)
         hpf_pkg::REG_PEAK_THR:  csr_prdata = 32'(peak_thr_ff);
         hpf_pkg::REG_VALID_THR: csr_prdata = 32'(valid_thr_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg.peak_thr  = peak_thr_ff;
   assign cfg.valid_thr = valid_thr_ff;

endmodule

>>> hw/rtl/hpf_front.sv
// Front end: accepts samples, tracks the map position and classifies each item.
module hpf_front #(
   parameter int MAP_ROWS   = 16,
   parameter int MAP_COLS   = 16,
   parameter int VALUE_BITS = 16,
   localparam int RB = $clog2(MAP_ROWS),
   localparam int CB = $clog2(MAP_COLS),
   localparam int EW = hpf_pkg::FLAGS_BITS + VALUE_BITS + RB + CB
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [VALUE_BITS-1:0] heat_value,
   input  logic                  map_start,
   output logic [EW-1:0]         entry
);

   localparam logic [RB-1:0] LAST_ROW = RB'(MAP_ROWS - 1);
   localparam logic [CB-1:0] LAST_COL = CB'(MAP_COLS - 1);

   logic [RB-1:0]      row_ff, row_in, cur_row;
   logic [CB-1:0]      col_ff, col_in, cur_col;
   hpf_pkg::flags_type flags;

   // A start mark forces row 0 of column 0
   assign cur_row = map_start ? '0 : row_ff;
   assign cur_col = map_start ? '0 : col_ff;

   // Classify the position
   always_comb begin
      flags.restart   = map_start;
      flags.first_col = (cur_col == '0);
      flags.end_row   = (cur_row == LAST_ROW);
      flags.last_col  = (cur_col == LAST_COL);
   end

   // Advance the position, wrap at the end of the map
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (push) begin
         if (flags.end_row) begin
            row_in = '0;
            col_in = flags.last_col ? '0 : cur_col + 1'b1;
         end else begin
            row_in = cur_row + 1'b1;
            col_in = cur_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign entry = {flags, heat_value, cur_row, cur_col};

endmodule

>>> hw/rtl/hpf_queue.sv
// Two-entry queue between the front end and the back end.
module hpf_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/hpf_back.sv
// Back end: column history, peak decisions, running maximum and result buffer.
module hpf_back #(
   parameter int MAP_ROWS   = 16,
   parameter int MAP_COLS   = 16,
   parameter int VALUE_BITS = 16,
   localparam int RB = $clog2(MAP_ROWS),
   localparam int CB = $clog2(MAP_COLS),
   localparam int EW = hpf_pkg::FLAGS_BITS + VALUE_BITS + RB + CB
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hpf_pkg::cfg_type      cfg,
   input  logic                  head_valid,
   input  logic [EW-1:0]         head_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CB-1:0]         rsp_column_index,
   output logic [MAP_ROWS-1:0]   rsp_peak_mask,
   output logic                  rsp_last_of_map,
   output logic                  rsp_map_valid,
   output logic [VALUE_BITS-1:0] rsp_map_maximum
);

   localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [CB-1:0]                LAST_COL = CB'(MAP_COLS - 1);

   typedef logic signed [VALUE_BITS-1:0] sval_type;

   // Peak test of one sample against its neighbors
   function automatic logic is_peak(sval_type c, sval_type up, sval_type dn, sval_type lf,
                                    sval_type thr, logic edge_col);
      logic ok;
      ok = (c > up) && (c > dn) && (c > lf) && (c > thr);
      return ok && (!edge_col || (c > sval_type'(0)));
   endfunction

   // Unpack the head item
   hpf_pkg::flags_type fl;
   logic [VALUE_BITS-1:0] v_raw;
   logic [RB-1:0]         row;
   logic [CB-1:0]         col;
   sval_type              v;

   assign {fl, v_raw, row, col} = head_data;
   assign v = sval_type'(v_raw);

   // Thresholds at sample width
   logic [VALUE_BITS+hpf_pkg::CFG_BITS-1:0] pthr_wide, vthr_wide;
   sval_type pthr, vthr;

   assign pthr_wide = {{VALUE_BITS{1'b0}}, cfg.peak_thr};
   assign vthr_wide = {{VALUE_BITS{1'b0}}, cfg.valid_thr};
   assign pthr      = sval_type'(pthr_wide[VALUE_BITS-1:0]);
   assign vthr      = sval_type'(vthr_wide[VALUE_BITS-1:0]);

   // State
   sval_type              hist_ff [MAP_ROWS+1];
   logic [MAP_ROWS-1:0]   cand_ff, cand_in;
   logic [MAP_ROWS-1:0]   pend_ff, pend_in;
   sval_type              max_ff, max_in;

   // Result buffer: slot 0 drives the port
   logic [CB-1:0]         ocol_ff   [2], ocol_in   [2];
   logic [MAP_ROWS-1:0]   omask_ff  [2], omask_in  [2];
   logic                  olast_ff  [2], olast_in  [2];
   logic                  ovalid_ff [2], ovalid_in [2];
   sval_type              omax_ff   [2], omax_in   [2];
   logic [1:0]            ocnt_ff, ocnt_in;

   // Neighbor selection and decisions
   logic [RB-1:0]         row_m1;
   sval_type              up_a, left_a, left_b, max_base, max_new;
   logic                  bit_a, bit_b, map_ok;
   logic [MAP_ROWS-1:0]   pend_base, pend_clr, cand_full;
   logic [1:0]            need, room, base;
   logic                  out_take;

   assign row_m1 = row - 1'b1;

   always_comb begin
      // row r decides row r-1; the last row also decides itself
      up_a   = (row > RB'(1)) ? hist_ff[1] : '0;
      left_a = fl.first_col ? '0 : hist_ff[MAP_ROWS];
      left_b = fl.first_col ? '0 : hist_ff[MAP_ROWS-1];
      bit_a  = is_peak(hist_ff[0], up_a, v, left_a, pthr, fl.last_col);
      bit_b  = is_peak(v, hist_ff[0], '0, left_b, pthr, fl.last_col);

      cand_in = cand_ff;
      if (row != '0) begin
         cand_in[row_m1] = bit_a;
      end
      cand_full = cand_in;
      cand_full[MAP_ROWS-1] = bit_b;

      // Drop a pending bit whose right neighbor is not smaller
      pend_base = fl.restart ? '0 : pend_ff;
      pend_clr  = pend_base;
      if (!fl.first_col && (v >= hist_ff[MAP_ROWS-1])) begin
         pend_clr[row] = 1'b0;
      end

      max_base = fl.restart ? VMIN : max_ff;
      max_new  = (v > max_base) ? v : max_base;
      map_ok   = (max_new >= vthr);

      // Results this item causes
      if (fl.end_row && !fl.first_col) begin
         need = fl.last_col ? 2'd2 : 2'd1;
      end else begin
         need = 2'd0;
      end
   end

   // Take the head item only when its results fit
   assign room     = 2'd2 - ocnt_ff;
   assign pop      = head_valid && (need <= room);
   assign rsp_valid = (ocnt_ff != 2'd0);
   assign out_take = rsp_valid && !rsp_stall;

   // Update map state
   always_comb begin
      pend_in = pend_ff;
      max_in  = max_ff;
      if (pop) begin
         pend_in = pend_clr;
         max_in  = max_new;
         if (fl.end_row) begin
            if (fl.last_col) begin
               pend_in = '0;
               max_in  = VMIN;
            end else begin
               pend_in = cand_full;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         max_ff  <= VMIN;
      end else begin
         pend_ff <= pend_in;
         max_ff  <= max_in;
      end
   end

   // Shift the sample into the history line
   always_ff @(posedge clock) begin
      if (pop) begin
         hist_ff[0] <= v;
         for (int k = 1; k <= MAP_ROWS; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
         cand_ff <= cand_in;
      end
   end

   // Drop the delivered result, append the new ones
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         ocol_in[k]   = ocol_ff[k];
         omask_in[k]  = omask_ff[k];
         olast_in[k]  = olast_ff[k];
         ovalid_in[k] = ovalid_ff[k];
         omax_in[k]   = omax_ff[k];
      end
      if (out_take) begin
         ocol_in[0]   = ocol_ff[1];
         omask_in[0]  = omask_ff[1];
         olast_in[0]  = olast_ff[1];
         ovalid_in[0] = ovalid_ff[1];
         omax_in[0]   = omax_ff[1];
      end
      base = ocnt_ff - 2'(out_take);
      if (pop && (need != 2'd0)) begin
         // mask of the previous column
         ocol_in[base[0]]   = col - 1'b1;
         omask_in[base[0]]  = pend_clr;
         olast_in[base[0]]  = 1'b0;
         ovalid_in[base[0]] = 1'b0;
         omax_in[base[0]]   = '0;
      end
      if (pop && (need == 2'd2)) begin
         // final column closes the map
         ocol_in[1]   = col;
         omask_in[1]  = cand_full;
         olast_in[1]  = 1'b1;
         ovalid_in[1] = map_ok;
         omax_in[1]   = max_new;
      end
      ocnt_in = base + (pop ? need : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= 2'd0;
      end else begin
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         ocol_ff[k]   <= ocol_in[k];
         omask_ff[k]  <= omask_in[k];
         olast_ff[k]  <= olast_in[k];
         ovalid_ff[k] <= ovalid_in[k];
         omax_ff[k]   <= omax_in[k];
      end
   end

   assign rsp_column_index = ocol_ff[0];
   assign rsp_peak_mask    = omask_ff[0];
   assign rsp_last_of_map  = olast_ff[0];
   assign rsp_map_valid    = ovalid_ff[0];
   assign rsp_map_maximum  = omax_ff[0];

   // The result buffer never overflows
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff != 2'd3)
      else $error("result buffer over two entries");

   // Reset empties the result buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (ocnt_ff == 2'd0))
      else $error("result buffer not empty after reset");

   // The closing result always reports the last column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_map) |-> (rsp_column_index == LAST_COL))
      else $error("map closed on wrong column");

   // Interior results carry no map summary
   a_inner_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_map) |-> (!rsp_map_valid && (rsp_map_maximum == '0)))
      else $error("summary on an interior column");

   // An item is taken only when its results fit in the buffer
   a_room: assert property (@(posedge clock) disable iff (reset)
      pop |=> (ocnt_ff <= 2'd2))
      else $error("item taken without room for its results");

endmodule

>>> hw/rtl/heatmap_peak_finder.sv
// Heatmap peak finder: one sample per cycle in, one peak mask per column out.
// Samples of a MAP_ROWS x MAP_COLS map arrive column by column (row fastest) and
// are taken one per clock cycle as long as the two-entry input queue has room.
// Each sample is decided against its four neighbors (outside the map they are
// zero) using a history line of MAP_ROWS+1 samples, so a column's mask leaves
// once the column to its right is complete. The last sample of a map produces
// two results: the mask of the next-to-last column and the mask of the last
// column with the map maximum and the valid flag. Each result is registered in
// a two-entry result buffer as its sample leaves the queue; the buffer absorbs the
// pair, and only a stalled result side holds back the input. No clearing pass
// follows reset: the block accepts items in the first cycle after it.
module heatmap_peak_finder #(
   parameter int MAP_ROWS   = 16,
   parameter int MAP_COLS   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // sample input
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [VALUE_BITS-1:0]      req_heat_value,
   input  logic                       req_map_start,
   // column results
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [$clog2(MAP_COLS)-1:0] rsp_column_index,
   output logic [MAP_ROWS-1:0]        rsp_peak_mask,
   output logic                       rsp_last_of_map,
   output logic                       rsp_map_valid,
   output logic [VALUE_BITS-1:0]      rsp_map_maximum,
   // configuration
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int RB = $clog2(MAP_ROWS);
   localparam int CB = $clog2(MAP_COLS);
   localparam int EW = hpf_pkg::FLAGS_BITS + VALUE_BITS + RB + CB;

   hpf_pkg::cfg_type cfg;
   logic             q_full, q_push, q_pop, q_valid;
   logic [EW-1:0]    f_entry, q_head;

   // Take a sample whenever the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   hpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hpf_front #(
      .MAP_ROWS   (MAP_ROWS),
      .MAP_COLS   (MAP_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .heat_value (req_heat_value),
      .map_start  (req_map_start),
      .entry      (f_entry)
   );

   hpf_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (f_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   hpf_back #(
      .MAP_ROWS   (MAP_ROWS),
      .MAP_COLS   (MAP_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (q_valid),
      .head_data        (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_index (rsp_column_index),
      .rsp_peak_mask    (rsp_peak_mask),
      .rsp_last_of_map  (rsp_last_of_map),
      .rsp_map_valid    (rsp_map_valid),
      .rsp_map_maximum  (rsp_map_maximum)
   );

endmodule
